// ===== src/ora_pkg.sv =====
// Shared types, constants and tables for the odometry rotate/accumulate unit.
package ora_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF   = 48;

  localparam int CORDIC_STEPS = 20;
  localparam int MUL_STEPS    = 6;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  // Multiply/accumulate sequence steps
  localparam logic [STEP_W-1:0] MS_DL_COS = STEP_W'(0);
  localparam logic [STEP_W-1:0] MS_DF_SIN = STEP_W'(1);
  localparam logic [STEP_W-1:0] MS_DF_COS = STEP_W'(2);
  localparam logic [STEP_W-1:0] MS_DL_SIN = STEP_W'(3);
  localparam logic [STEP_W-1:0] MS_FWD    = STEP_W'(4);
  localparam logic [STEP_W-1:0] MS_ACC_F  = STEP_W'(5);

  localparam logic OP_HEADING = 1'b0;
  localparam logic OP_ENCODER = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] yaw_angle;
    logic signed [31:0] enc_left_um;
    logic signed [31:0] enc_forward_um;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] pos_left_um;
    logic signed [47:0] pos_forward_um;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_FIX,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              is_enc;
    logic              cordic_en;
    logic              fix_en;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } cmd_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ora_ctrl.sv =====
// Sequencer for the odometry unit: handshakes, CORDIC and multiply step counts.
module ora_ctrl
  import ora_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = (in_op == OP_ENCODER) ? ST_CORDIC : ST_DONE;
        end
      end
      ST_CORDIC: begin
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_FIX;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIX: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.is_enc    = in_op;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_CORDIC: cmd.cordic_en = 1'b1;
      ST_FIX:    cmd.fix_en = 1'b1;
      ST_MUL:    cmd.mul_en = 1'b1;
      ST_DONE:   cmd.out_load = out_free;
      default:   in_ready = 1'b0;
    endcase
    cmd.start = in_valid && in_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/ora_dp.sv =====
// Datapath: heading/encoder state, iterative CORDIC, shared multiplier, accumulators.
module ora_dp
  import ora_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int ACC_BITS   = ACC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cmd_t     cmd,
  input  in_req_t  in_data,
  output out_rsp_t out_data
);

  localparam int CW     = 34;  // CORDIC x/y/z width
  localparam int PROD_W = 49;
  localparam int SUM_W  = 50;
  localparam int TERM_W = SUM_W - 15;
  localparam logic signed [CW-1:0]    X_INIT = CW'(652032874);
  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(16384);

  function automatic logic signed [15:0] q15_round(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW-15:0] r;
    t = (CW+1)'(v) + (CW+1)'(16384);
    r = (CW-14)'(t >>> 15);
    if (r > (CW-14)'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -(CW-14)'(32768)) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  logic [ANGLE_BITS-1:0]      heading_r;
  logic signed [31:0]         last_l_r, last_f_r;
  logic signed [32:0]         dl_r, df_r;
  logic signed [CW-1:0]       x_r, y_r, z_r;
  logic                       flip_r;
  logic signed [15:0]         c_r, s_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [ACC_BITS-1:0] acc_l_r, acc_f_r;
  out_rsp_t                   out_r;

  logic [31:0]          yaw_ext;
  logic [31:0]          ang0, ang1;
  logic                 flip0;
  logic signed [CW-1:0] xs, ys, at, xf, yf;
  logic signed [32:0]   mul_a;
  logic signed [15:0]   mul_b;
  logic signed [TERM_W-1:0] term;
  logic [63:0]          term64, out_l64, out_f64;

  assign yaw_ext = {in_data.yaw_angle, 16'h0000};
  assign ang0    = {heading_r, {(32 - ANGLE_BITS){1'b0}}};
  assign flip0   = ang0[31] ^ ang0[30];
  assign ang1    = flip0 ? {~ang0[31], ang0[30:0]} : ang0;

  assign xs = x_r >>> cmd.step;
  assign ys = y_r >>> cmd.step;
  assign at = signed'({2'b00, cordic_atan(cmd.step)});
  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;

  always_comb begin
    case (cmd.step)
      MS_DF_SIN: begin mul_a = df_r; mul_b = s_r; end
      MS_DF_COS: begin mul_a = df_r; mul_b = c_r; end
      MS_DL_SIN: begin mul_a = dl_r; mul_b = s_r; end
      default:   begin mul_a = dl_r; mul_b = c_r; end
    endcase
  end

  assign term   = TERM_W'(sum_r >>> 15);
  assign term64 = 64'(term);

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      last_l_r  <= '0;
      last_f_r  <= '0;
      acc_l_r   <= '0;
      acc_f_r   <= '0;
    end else begin
      if (cmd.start && cmd.is_enc == OP_HEADING) begin
        heading_r <= yaw_ext[31 -: ANGLE_BITS];
      end
      if (cmd.start && cmd.is_enc == OP_ENCODER) begin
        last_l_r <= in_data.enc_left_um;
        last_f_r <= in_data.enc_forward_um;
      end
      if (cmd.mul_en && cmd.step == MS_DL_SIN) begin
        acc_l_r <= acc_l_r + term64[ACC_BITS-1:0];
      end
      if (cmd.mul_en && cmd.step == MS_ACC_F) begin
        acc_f_r <= acc_f_r + term64[ACC_BITS-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dl_r   <= 33'(in_data.enc_left_um) - 33'(last_l_r);
      df_r   <= 33'(in_data.enc_forward_um) - 33'(last_f_r);
      x_r    <= X_INIT;
      y_r    <= '0;
      z_r    <= CW'(signed'(ang1));
      flip_r <= flip0;
    end else if (cmd.cordic_en) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.fix_en) begin
      c_r <= q15_round(xf);
      s_r <= q15_round(yf);
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      case (cmd.step)
        MS_DF_SIN: sum_r <= SUM_W'(prod_r);
        MS_DF_COS: sum_r <= sum_r + SUM_W'(prod_r) + RND;
        MS_DL_SIN: sum_r <= SUM_W'(prod_r);
        MS_FWD:    sum_r <= sum_r - SUM_W'(prod_r) + RND;
        default:   sum_r <= sum_r;
      endcase
    end
  end

  assign out_l64 = 64'(acc_l_r);
  assign out_f64 = 64'(acc_f_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.pos_left_um    <= out_l64[47:0];
      out_r.pos_forward_um <= out_f64[47:0];
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/odometry_rotate_accumulate_unit.sv =====
// Top level of the planar dead-reckoning odometry unit.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one request per heading update
//   (operation 0, yaw_angle as a binary angle, 65536 per turn) or encoder
//   sample (operation 1, cumulative left/forward positions in um).
//   Result channel (out_valid/out_ready/out_data): one result per request with
//   the accumulated world-frame position in um, wrapping at ACC_BITS.
// Sequencing:
//   Heading request: no CORDIC or multiply steps; it goes straight to the
//   output load. Encoder request: 20 CORDIC iterations, a rounding step,
//   the multiply steps on the shared 33x16 multiplier and the output load.
//   The iterative CORDIC sets the rate: one request in flight, and a new
//   request is taken only once the last one has reached its output load.
// Reset (rst_n low, synchronous): heading, last encoder positions and both
//   accumulators clear to zero; no result pending.
// Stall: a finished result sits in the output register; a new request is
//   still accepted and computed, and waits before loading until the pending
//   result has been taken.
module odometry_rotate_accumulate_unit
  import ora_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int ACC_BITS   = ACC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  cmd_t cmd;

  // sequencer: handshakes and step counting
  ora_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // state, CORDIC, multiply/accumulate and output register
  ora_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== sim/odometry_position_checker.sv =====
// Position checker for the odometry unit: tracks requests, predicts results, compares them.
module odometry_position_checker
  import ora_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_data,
  output int       mismatches,
  output int       positions_due
);

  localparam int     HDG_W           = ANGLE_BITS_DEF;
  localparam int     ACC_W           = ACC_BITS_DEF;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  logic [HDG_W-1:0] heading_q;
  logic [31:0]      last_left_q;
  logic [31:0]      last_fwd_q;
  logic [ACC_W-1:0] acc_left_q;
  logic [ACC_W-1:0] acc_fwd_q;
  out_rsp_t         expected_pos_q[$];

  // atan(2^-i), 2^32 per turn
  function automatic longint atan_turn32(input int i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051E;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2F;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2FA;
      15:      return 64'h0000517D;
      16:      return 64'h000028BE;
      17:      return 64'h0000145F;
      18:      return 64'h00000A30;
      default: return 64'h00000518;
    endcase
  endfunction

  // Q2.30 -> Q1.15, nearest with ties up, saturated
  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // Applies one request to the tracked pose and returns the position it reports.
  function automatic out_rsp_t track_position(input in_req_t r);
    logic [31:0] ang;
    logic [31:0] quad;
    logic        flip;
    longint      x, y, z, xs, ys;
    longint      c, s, dl, df, tl, tf;
    out_rsp_t    pos;
    if (r.operation == OP_HEADING) begin
      ang = {r.yaw_angle, 16'h0000};
      heading_q = HDG_W'(ang >> (32 - HDG_W));
    end else begin
      dl = longint'($signed(r.enc_left_um)) - longint'($signed(last_left_q));
      df = longint'($signed(r.enc_forward_um)) - longint'($signed(last_fwd_q));
      last_left_q = r.enc_left_um;
      last_fwd_q  = r.enc_forward_um;
      // fold into the right half-plane, rotate, unfold
      ang  = 32'(heading_q) << (32 - HDG_W);
      quad = ang + 32'h4000_0000;
      flip = quad[31];
      if (flip) ang = ang ^ 32'h8000_0000;
      x = CORDIC_GAIN_Q30;
      y = 0;
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - atan_turn32(i);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + atan_turn32(i);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c  = round_q15(x);
      s  = round_q15(y);
      tl = (dl * c + df * s + 64'sd16384) >>> 15;
      tf = (df * c - dl * s + 64'sd16384) >>> 15;
      acc_left_q = acc_left_q + ACC_W'(tl);
      acc_fwd_q  = acc_fwd_q + ACC_W'(tf);
    end
    pos.pos_left_um    = 48'($signed(acc_left_q));
    pos.pos_forward_um = 48'($signed(acc_fwd_q));
    return pos;
  endfunction

  always @(posedge clk) begin : watch
    out_rsp_t due;
    if (!rst_n) begin
      heading_q     = '0;
      last_left_q   = '0;
      last_fwd_q    = '0;
      acc_left_q    = '0;
      acc_fwd_q     = '0;
      expected_pos_q.delete();
      mismatches    = 0;
      positions_due = 0;
    end else begin
      // a result never belongs to a request taken on the same edge
      if (out_valid && out_ready) begin
        if (expected_pos_q.size() == 0) begin
          $error("position result with no request outstanding");
          mismatches++;
        end else begin
          due = expected_pos_q.pop_front();
          if (out_data.pos_left_um !== due.pos_left_um) begin
            $error("pos_left_um: expected %0d, got %0d",
                   due.pos_left_um, out_data.pos_left_um);
            mismatches++;
          end
          if (out_data.pos_forward_um !== due.pos_forward_um) begin
            $error("pos_forward_um: expected %0d, got %0d",
                   due.pos_forward_um, out_data.pos_forward_um);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) expected_pos_q.push_back(track_position(in_data));
      positions_due = expected_pos_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the odometry rotate/accumulate unit: stimulus, handshakes and verdict.
module tb;
  import ora_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;

  bit       gaps_on;        // random idling on both channels
  int       mismatches;
  int       positions_due;  // requests whose result has not come back yet

  // Encoder positions last sent, so incremental samples look like real motion.
  logic signed [31:0] enc_left_now;
  logic signed [31:0] enc_fwd_now;

  odometry_rotate_accumulate_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  odometry_position_checker position_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .positions_due (positions_due)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: out_ready drops at random, about 7 percent of the time, while gaps are enabled.
  always @(negedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(99) < 7);
  end

  // Headings at the octant and quadrant edges; the quarter-turn edges
  // decide whether the rotation is folded through a half turn.
  function automatic logic signed [15:0] corner_yaw(input int k);
    case (k)
      0:       return 16'sd0;
      1:       return 16'sd16384;
      2:       return -16'sd32768;
      3:       return 16'sd16383;
      4:       return -16'sd16384;
      5:       return -16'sd16385;
      6:       return 16'sd32767;
      7:       return 16'sd8192;
      8:       return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] encoder_corner();
    case ($urandom_range(4))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'($urandom_range(3));
    endcase
  endfunction

  // Heading request; the encoder fields carry junk the unit must ignore.
  function automatic in_req_t heading_req(input logic signed [15:0] yaw);
    in_req_t r;
    r.operation      = OP_HEADING;
    r.yaw_angle      = yaw;
    r.enc_left_um    = $urandom;
    r.enc_forward_um = $urandom;
    return r;
  endfunction

  // Encoder request; the yaw field is junk.
  function automatic in_req_t encoder_req(input logic signed [31:0] left_pos,
                                          input logic signed [31:0] fwd_pos);
    in_req_t r;
    r.operation      = OP_ENCODER;
    r.yaw_angle      = 16'($urandom);
    r.enc_left_um    = left_pos;
    r.enc_forward_um = fwd_pos;
    enc_left_now     = left_pos;
    enc_fwd_now      = fwd_pos;
    return r;
  endfunction

  // Entered and left at a falling edge. Valid stays up between back-to-back
  // requests; it only drops during a random gap.
  task automatic push_request(input in_req_t r);
    while (gaps_on && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int                 pick;
    logic signed [15:0] yaw;
    logic signed [31:0] left_pos;
    logic signed [31:0] fwd_pos;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    gaps_on      = 1'b1;
    enc_left_now = '0;
    enc_fwd_now  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: the first sample is differenced against zero, then every
    // corner heading is followed by a sample with full-scale or random swings.
    push_request(encoder_req(32'sd123456, -32'sd654321));
    for (int k = 0; k < 10; k++) begin
      push_request(heading_req(corner_yaw(k)));
      case (k % 4)
        0:       push_request(encoder_req(32'sh7FFF_FFFF, 32'sh8000_0000));
        1:       push_request(encoder_req(32'sh8000_0000, 32'sh7FFF_FFFF));
        2:       push_request(encoder_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        default: push_request(encoder_req($urandom, $urandom));
      endcase
    end

    // Random: mostly small motion between samples, some jumps and extremes.
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) begin
        // let the unit drain completely before carrying on
        in_valid <= 1'b0;
        while (positions_due != 0) @(negedge clk);
      end
      gaps_on <= !(n >= 600 && n < 800);
      pick = $urandom_range(9);
      if (pick < 3) begin
        if ($urandom_range(7) == 0) yaw = corner_yaw($urandom_range(9));
        else yaw = 16'($urandom);
        push_request(heading_req(yaw));
      end else begin
        case ($urandom_range(3))
          0: begin
            left_pos = $urandom;
            fwd_pos  = $urandom;
          end
          1, 2: begin
            left_pos = enc_left_now + 32'($urandom_range(20000)) - 32'sd10000;
            fwd_pos  = enc_fwd_now + 32'($urandom_range(20000)) - 32'sd10000;
          end
          default: begin
            left_pos = encoder_corner();
            fwd_pos  = encoder_corner();
          end
        endcase
        push_request(encoder_req(left_pos, fwd_pos));
      end
    end

    in_valid <= 1'b0;
    while (positions_due != 0) @(negedge clk);
    // catch any stray result beyond the longest latency
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard, far longer than the slowest legal run.
  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/ora_pkg.sv
src/ora_ctrl.sv
src/ora_dp.sv
src/odometry_rotate_accumulate_unit.sv
sim/odometry_position_checker.sv
sim/tb.sv
